### sv/heading_hold_deviation_unit_assert.svh
// assertion macros shared by the heading hold deviation modules
// needs signals named clk and arst_n in the module that uses them
`ifndef HEADING_HOLD_DEVIATION_UNIT_ASSERT_SVH
`define HEADING_HOLD_DEVIATION_UNIT_ASSERT_SVH

// consequent checked in the same cycle
`define HHD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define HHD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/hhd_pkg.sv
// widths, constants and the step control struct of the heading hold deviation unit
// no dependencies
`default_nettype none

package hhd_pkg;

	localparam int ReadingW = 12;
	localparam int TargetW  = 9;
	localparam int ErrW     = 6;
	localparam int DevW     = 8;
	localparam int GainW    = 5;
	localparam int DiffW    = 10;
	localparam int AccW     = 17;

	// shared multiply-add operand and result widths
	localparam int MacAW = 13;
	localparam int MacBW = 14;
	localparam int MacCW = 14;
	localparam int MacW  = 28;

	// floor(r / 15) == ((r + 1) * 4369) >> 16 for r below 4096
	localparam logic signed [MacBW-1:0] Recip15   = 14'sd4369;
	localparam int                      RecipShift = 16;
	localparam logic signed [MacBW-1:0] MinusOne  = -14'sd1;
	localparam logic signed [MacBW-1:0] MulThree  = 14'sd3;

	localparam logic [TargetW-1:0] NoHeading = 9'd255;

	localparam logic signed [DiffW-1:0] WrapHalf = 10'sd120;
	localparam logic signed [DiffW-1:0] WrapTurn = 10'sd240;
	localparam logic signed [DiffW-1:0] ErrLimit = 10'sd20;

	// configuration register indexes
	localparam logic RegEnable = 1'b0;
	localparam logic RegGain   = 1'b1;

	localparam logic [GainW-1:0] GainReset = 5'd16;

	// which step the sequencer is in
	typedef struct packed {
		logic div;
		logic err;
		logic acc1;
		logic acc2;
		logic fin;
	} hhd_step_t;

endpackage

`default_nettype wire

### sv/heading_hold_deviation_unit.sv
// top level of the heading hold deviation unit: registers, operand steering, result
// depends on hhd_pkg, hhd_mac, hhd_ctrl and heading_hold_deviation_unit_assert.svh
`default_nettype none

//  channel   signals                                   direction
//  input     in_valid in_ready compass_reading         in, one reading per item
//  output    out_valid out_ready deviation             out, one result per item
//            clamped_error holding
//  config    cfg_we cfg_idx cfg_data                   in, write only, no wait
//
//  an enabled item with a stored target passes from accept through four steps on
//  the shared multiply-add (div, err, acc1, acc2) and then the finish step; a
//  countdown item skips acc1 and acc2, a disabled item goes straight to finish
//  reset is asynchronous and active low; it clears the target to the no heading
//  marker, the deviation to zero and the config to its reset values
//  a result waits in the output register while the next item is taken; the
//  finish step stalls only while that register still holds an untaken result

`include "heading_hold_deviation_unit_assert.svh"

module heading_hold_deviation_unit
	import hhd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [ReadingW-1:0]    compass_reading,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic signed [DevW-1:0]      deviation,
	output logic signed [ErrW-1:0]      clamped_error,
	output logic                        holding,
	input  wire logic                   cfg_we,
	input  wire logic                   cfg_idx,
	input  wire logic [GainW-1:0]       cfg_data
);

	// config registers
	logic             enable_q;
	logic [GainW-1:0] gain_q;

	// persistent state
	logic [TargetW-1:0]          target_q;
	logic signed [DevW-1:0]      dev_q;

	// per item working registers
	logic [ReadingW-1:0]         reading_q;
	logic [TargetW-1:0]          heading_q;
	logic signed [ErrW-1:0]      err_q;
	logic signed [DiffW-1:0]     sum_q;

	// finished result waiting for the output register
	logic signed [DevW-1:0]      res_dev_q;
	logic signed [ErrW-1:0]      res_err_q;
	logic                        res_hold_q;

	// output register
	logic                        out_valid_q;
	logic signed [DevW-1:0]      out_dev_q;
	logic signed [ErrW-1:0]      out_err_q;
	logic                        out_hold_q;

	hhd_step_t                   step;
	logic                        accept;
	logic                        countdown;
	logic                        capture;
	logic                        out_free;

	logic signed [MacAW-1:0]     mac_a;
	logic signed [MacBW-1:0]     mac_b;
	logic signed [MacCW-1:0]     mac_c;
	logic signed [MacW-1:0]      mac_res;

	logic signed [ErrW-1:0]      err_new;
	logic signed [DevW-1:0]      dev_new;

	// wrap once into (-120, 120], then clamp to +-20
	function automatic logic signed [ErrW-1:0] wrap_clamp(input logic signed [DiffW-1:0] d);
		logic signed [DiffW-1:0] w;
		logic signed [DiffW-1:0] c;
		if (d <= -WrapHalf) begin
			w = d + WrapTurn;
		end else if (d > WrapHalf) begin
			w = d - WrapTurn;
		end else begin
			w = d;
		end
		if (w < -ErrLimit) begin
			c = -ErrLimit;
		end else if (w > ErrLimit) begin
			c = ErrLimit;
		end else begin
			c = w;
		end
		return c[ErrW-1:0];
	endfunction

	// floor shift by 8 is the upper bits; then saturate to 8 bits signed
	function automatic logic signed [DevW-1:0] shift_sat(input logic signed [AccW-1:0] acc);
		logic signed [AccW-9:0] sh;
		logic signed [DevW-1:0] r;
		sh = acc[AccW-1:8];
		if (sh > 9'sd127) begin
			r = 8'sd127;
		end else if (sh < -9'sd128) begin
			r = -8'sd128;
		end else begin
			r = sh[DevW-1:0];
		end
		return r;
	endfunction

	assign accept    = in_valid && in_ready;
	assign countdown = (target_q > NoHeading);
	assign capture   = (target_q == NoHeading);
	assign out_free  = !out_valid_q || out_ready;

	hhd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.enable    (enable_q),
		.countdown (countdown),
		.out_free  (out_free),
		.in_ready  (in_ready),
		.step      (step)
	);

	// operand steering of the shared multiply-add
	// div:  (reading + 1) * 4369, heading in bits 24:16
	// err:  target - heading, the captured heading stands in for the marker
	// acc1: 3 * deviation + error
	// acc2: sum * 4 * gain
	always_comb begin
		mac_a = '0;
		mac_b = '0;
		mac_c = '0;
		priority if (step.div) begin
			mac_a = {1'b0, reading_q};
			mac_b = Recip15;
			mac_c = Recip15;
		end else if (step.err) begin
			mac_a = {{(MacAW-TargetW){1'b0}}, heading_q};
			mac_b = MinusOne;
			mac_c = {{(MacCW-TargetW){1'b0}}, capture ? heading_q : target_q};
		end else if (step.acc1) begin
			mac_a = {{(MacAW-DevW){dev_q[DevW-1]}}, dev_q};
			mac_b = MulThree;
			mac_c = {{(MacCW-ErrW){err_q[ErrW-1]}}, err_q};
		end else if (step.acc2) begin
			mac_a = {{(MacAW-DiffW){sum_q[DiffW-1]}}, sum_q};
			mac_b = {{(MacBW-GainW-2){1'b0}}, gain_q, 2'b00};
			mac_c = '0;
		end
	end

	hhd_mac u_mac (
		.a   (mac_a),
		.b   (mac_b),
		.c   (mac_c),
		.res (mac_res)
	);

	assign err_new = wrap_clamp(mac_res[DiffW-1:0]);
	assign dev_new = shift_sat(mac_res[AccW-1:0]);

	// config writes, to be made only while idle; the block itself does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			gain_q   <= GainReset;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				RegEnable: enable_q <= cfg_data[0];
				RegGain:   gain_q   <= cfg_data;
				default:   ;
			endcase
		end
	end

	// target and deviation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= NoHeading;
			dev_q    <= '0;
		end else if (step.err) begin
			if (countdown) begin
				target_q <= target_q - 1'b1;
				dev_q    <= '0;
			end else if (capture) begin
				target_q <= heading_q;
				dev_q    <= '0;
			end
		end else if (step.acc2) begin
			dev_q <= dev_new;
		end
	end

	// working and result registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			reading_q <= compass_reading;
			if (!enable_q) begin
				res_dev_q  <= dev_q;
				res_err_q  <= '0;
				res_hold_q <= 1'b0;
			end
		end
		if (step.div) begin
			heading_q <= mac_res[RecipShift +: TargetW];
		end
		if (step.err) begin
			err_q <= err_new;
			if (countdown) begin
				res_dev_q  <= '0;
				res_err_q  <= '0;
				res_hold_q <= 1'b0;
			end
		end
		if (step.acc1) begin
			sum_q <= mac_res[DiffW-1:0];
		end
		if (step.acc2) begin
			res_dev_q  <= dev_new;
			res_err_q  <= err_q;
			res_hold_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step.fin && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.fin && out_free) begin
			out_dev_q  <= res_dev_q;
			out_err_q  <= res_err_q;
			out_hold_q <= res_hold_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign deviation     = out_dev_q;
	assign clamped_error = out_err_q;
	assign holding       = out_hold_q;

	`HHD_ASSERT_SAME(a_err_range, out_valid, (clamped_error >= -6'sd20) && (clamped_error <= 6'sd20), "clamped error out of range")
	`HHD_ASSERT_SAME(a_idle_err_zero, out_valid && !holding, clamped_error == '0, "error set without holding")

endmodule

`default_nettype wire

### sv/hhd_mac.sv
// shared signed multiply-add unit, res = a * b + c
// depends on hhd_pkg
`default_nettype none

module hhd_mac
	import hhd_pkg::*;
(
	input  wire logic signed [MacAW-1:0] a,
	input  wire logic signed [MacBW-1:0] b,
	input  wire logic signed [MacCW-1:0] c,
	output logic signed [MacW-1:0]       res
);

	logic signed [MacAW+MacBW-1:0] prod;

	assign prod = a * b;
	assign res  = {prod[MacAW+MacBW-1], prod} + {{(MacW-MacCW){c[MacCW-1]}}, c};

endmodule

`default_nettype wire

### sv/hhd_ctrl.sv
// step sequencer of the heading hold deviation unit
// depends on hhd_pkg and heading_hold_deviation_unit_assert.svh
`default_nettype none

`include "heading_hold_deviation_unit_assert.svh"

module hhd_ctrl
	import hhd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic enable,
	input  wire logic countdown,
	input  wire logic out_free,
	output logic      in_ready,
	output hhd_step_t step
);

	localparam logic [2:0] SIdle = 3'd0;
	localparam logic [2:0] SDiv  = 3'd1;
	localparam logic [2:0] SErr  = 3'd2;
	localparam logic [2:0] SAcc1 = 3'd3;
	localparam logic [2:0] SAcc2 = 3'd4;
	localparam logic [2:0] SFin  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign in_ready = (state_q == SIdle);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SIdle: if (accept) state_d = enable ? SDiv : SFin;
			SDiv:  state_d = SErr;
			SErr:  state_d = countdown ? SFin : SAcc1;
			SAcc1: state_d = SAcc2;
			SAcc2: state_d = SFin;
			SFin:  if (out_free) state_d = SIdle;
			default: state_d = SIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SIdle;
		end else begin
			state_q <= state_d;
		end
	end

	assign step.div  = (state_q == SDiv);
	assign step.err  = (state_q == SErr);
	assign step.acc1 = (state_q == SAcc1);
	assign step.acc2 = (state_q == SAcc2);
	assign step.fin  = (state_q == SFin);

	`HHD_ASSERT_NEXT(a_skip_when_off, accept && !enable, state_q == SFin, "disabled item not sent to finish")
	`HHD_ASSERT_NEXT(a_countdown_fin, step.err && countdown, state_q == SFin, "countdown did not finish")
	`HHD_ASSERT_NEXT(a_acc_fin, step.acc2, state_q == SFin, "smoothing did not finish")

endmodule

`default_nettype wire
